// ===== hdl/ssrm_pkg.sv =====
// Shared types and constants for the stream sector region mapper.
// Depends on nothing; every other file in hdl/ refers to it by scoped name.
package ssrm_pkg;

  // Region table sizing
  localparam int MAX_REGIONS = 16;
  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // Stream geometry
  localparam int OFFSET_W = 40;
  localparam int IMAGE_W = 36;
  localparam logic [31:0] MAIN_HDR_SECTORS = 32'h0000_2000;
  localparam logic [31:0] SUB_HDR_SECTORS = 32'h0000_0800;
  localparam logic [9:0] SECTOR_BYTES = 10'd512;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = {OFFSET_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_DATA   = 2'd2,
    REQ_FINISH = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_SPACE   = 3'd1,
    ST_SHORT      = 3'd2,
    ST_NOT_OPEN   = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_CMP,
    S_LBA,
    S_RESULT
  } state_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] part_start_lba;
    logic [31:0] part_length_sectors;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        write_valid;
    logic [31:0] dest_lba;
    logic [8:0]  byte_in_sector;
    logic [7:0]  out_byte;
    logic [8:0]  pad_count;
  } res_t;

  typedef struct packed {
    logic [31:0] first_lba;
    logic [31:0] offset_sectors;
    logic [31:0] capacity_sectors;
  } region_entry_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] diff;
  } match_t;

endpackage

// ===== hdl/stream_sector_region_mapper.sv =====
// Stream sector region mapper: sequencer, stream state and result register.
// Depends on ssrm_pkg and ssrm_region_map.
//
// Maps a linear image stream onto up to MAX_REGIONS disk regions, one request
// at a time. Begin, load, finish on an aligned position and any request refused
// without a scan reach the result register through EXEC and RESULT, which waits
// for the register to be free. A data byte, or a finish that pads a partial
// sector, runs through the table's single read port and the shared match unit,
// adding READ, CMP and LBA, when the byte falls in the region that held the
// previous byte; otherwise the scan from the first region adds a READ and CMP
// pass for each entry read beyond one, and one more when the previous byte's
// region was tried first and missed. A new request is taken as soon as the
// result is in the result register, even while it waits to be taken. The
// no-space error is raised at the first byte that maps nowhere and stays until
// the next begin. There is no clearing pass after reset.
module stream_sector_region_mapper (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  ssrm_pkg::req_t                req_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output ssrm_pkg::res_t                res_data,
  input  logic                          cfg_we,
  input  logic [ssrm_pkg::IMAGE_W-1:0]  cfg_data
);

  ssrm_pkg::state_t state, state_next;
  ssrm_pkg::req_t   req_q;
  ssrm_pkg::res_t   res_q, res_q_next;

  logic [ssrm_pkg::IMAGE_W-1:0]  expected_len;
  logic [ssrm_pkg::OFFSET_W-1:0] stream_offset, stream_offset_next;
  logic                          error_flag, error_flag_next;
  logic                          stream_open, stream_open_next;
  logic [ssrm_pkg::CNT_W-1:0]    region_total, region_total_next;
  logic [31:0]                   next_region_offset, next_region_offset_next;
  logic                          cache_valid, cache_valid_next;
  logic [ssrm_pkg::IDX_W-1:0]    cache_idx, cache_idx_next;
  logic                          cache_try, cache_try_next;
  logic [ssrm_pkg::IDX_W-1:0]    scan_idx, scan_idx_next;
  logic [31:0]                   diff_q, diff_q_next;
  logic                          res_valid_next;

  logic                          accept;
  logic                          tbl_we;
  ssrm_pkg::region_entry_t       tbl_entry;
  logic [31:0]                   sector;
  logic [31:0]                   rd_start;
  ssrm_pkg::match_t              match;

  logic [31:0] hdr;
  logic [31:0] cap;
  logic [32:0] offset_sum;
  logic [8:0]  part;
  logic [9:0]  pad;
  logic [ssrm_pkg::OFFSET_W:0] end_pos;
  logic        scan_last;

  assign req_stall = (state != ssrm_pkg::S_IDLE);
  assign accept = req_valid && !req_stall;
  assign sector = {1'b0, stream_offset[ssrm_pkg::OFFSET_W-1:9]};
  assign part = stream_offset[8:0];

  ssrm_region_map u_map (
    .clk      (clk),
    .wr_en    (tbl_we),
    .wr_idx   (region_total[ssrm_pkg::IDX_W-1:0]),
    .wr_entry (tbl_entry),
    .rd_idx   (scan_idx),
    .sector   (sector),
    .rd_start (rd_start),
    .match    (match)
  );

  // Region arithmetic for a load request
  always_comb begin
    hdr = (region_total == '0) ? ssrm_pkg::MAIN_HDR_SECTORS : ssrm_pkg::SUB_HDR_SECTORS;
    cap = (req_q.part_length_sectors > hdr) ? (req_q.part_length_sectors - hdr) : 32'd0;
    offset_sum = {1'b0, next_region_offset} + {1'b0, cap};
    tbl_entry.first_lba = req_q.part_start_lba + hdr;
    tbl_entry.offset_sectors = next_region_offset;
    tbl_entry.capacity_sectors = cap;
  end

  // Padding and padded end for a finish request
  always_comb begin
    pad = ssrm_pkg::SECTOR_BYTES - {1'b0, part};
    end_pos = {1'b0, stream_offset} + {{(ssrm_pkg::OFFSET_W - 9){1'b0}}, pad};
  end

  assign scan_last = ((ssrm_pkg::CNT_W)'(scan_idx) + (ssrm_pkg::CNT_W)'(1)) >= region_total;

  // Sequencer: next state and datapath updates
  always_comb begin
    state_next = state;
    res_q_next = res_q;
    stream_offset_next = stream_offset;
    error_flag_next = error_flag;
    stream_open_next = stream_open;
    region_total_next = region_total;
    next_region_offset_next = next_region_offset;
    cache_valid_next = cache_valid;
    cache_idx_next = cache_idx;
    cache_try_next = cache_try;
    scan_idx_next = scan_idx;
    diff_q_next = diff_q;
    tbl_we = 1'b0;
    res_valid_next = res_valid && res_stall;

    unique case (state)
      ssrm_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ssrm_pkg::S_EXEC;
        end
      end

      ssrm_pkg::S_EXEC: begin
        res_q_next = '0;
        state_next = ssrm_pkg::S_RESULT;
        // Start a search from the last hit region, or from the first
        scan_idx_next = cache_valid ? cache_idx : '0;
        cache_try_next = cache_valid;
        if (req_q.req_type == ssrm_pkg::REQ_BEGIN) begin
          region_total_next = '0;
          next_region_offset_next = '0;
          stream_offset_next = '0;
          error_flag_next = 1'b0;
          stream_open_next = 1'b1;
          cache_valid_next = 1'b0;
        end else if (!stream_open) begin
          res_q_next.status = ssrm_pkg::ST_NOT_OPEN;
        end else begin
          case (req_q.req_type)
            ssrm_pkg::REQ_LOAD: begin
              if (region_total >= (ssrm_pkg::CNT_W)'(ssrm_pkg::MAX_REGIONS)) begin
                res_q_next.status = ssrm_pkg::ST_TABLE_FULL;
              end else begin
                tbl_we = 1'b1;
                next_region_offset_next = offset_sum[32] ? 32'hFFFF_FFFF : offset_sum[31:0];
                region_total_next = region_total + (ssrm_pkg::CNT_W)'(1);
                cache_valid_next = 1'b0;
              end
            end
            ssrm_pkg::REQ_DATA: begin
              if (error_flag || stream_offset == ssrm_pkg::OFFSET_MAX ||
                  region_total == '0) begin
                error_flag_next = 1'b1;
                res_q_next.status = ssrm_pkg::ST_NO_SPACE;
              end else begin
                state_next = ssrm_pkg::S_READ;
              end
            end
            default: begin
              // Finish: aligned position needs no padding sector
              if (error_flag) begin
                res_q_next.status = ssrm_pkg::ST_NO_SPACE;
                stream_open_next = 1'b0;
              end else if (part == '0) begin
                if (stream_offset < (ssrm_pkg::OFFSET_W)'(expected_len)) begin
                  res_q_next.status = ssrm_pkg::ST_SHORT;
                end
                stream_open_next = 1'b0;
              end else if (region_total == '0) begin
                res_q_next.status = ssrm_pkg::ST_NO_SPACE;
                stream_open_next = 1'b0;
              end else begin
                state_next = ssrm_pkg::S_READ;
              end
            end
          endcase
        end
      end

      ssrm_pkg::S_READ: begin
        state_next = ssrm_pkg::S_CMP;
      end

      ssrm_pkg::S_CMP: begin
        if (match.hit) begin
          diff_q_next = match.diff;
          state_next = ssrm_pkg::S_LBA;
        end else if (cache_try) begin
          // Cached region missed: rescan from the first
          cache_try_next = 1'b0;
          scan_idx_next = '0;
          state_next = ssrm_pkg::S_READ;
        end else if (scan_last) begin
          // Sector lies in no region
          res_q_next.status = ssrm_pkg::ST_NO_SPACE;
          if (req_q.req_type == ssrm_pkg::REQ_DATA) begin
            error_flag_next = 1'b1;
          end else begin
            stream_open_next = 1'b0;
          end
          state_next = ssrm_pkg::S_RESULT;
        end else begin
          scan_idx_next = scan_idx + (ssrm_pkg::IDX_W)'(1);
          state_next = ssrm_pkg::S_READ;
        end
      end

      ssrm_pkg::S_LBA: begin
        res_q_next.write_valid = 1'b1;
        res_q_next.dest_lba = rd_start + diff_q;
        res_q_next.byte_in_sector = part;
        cache_valid_next = 1'b1;
        cache_idx_next = scan_idx;
        if (req_q.req_type == ssrm_pkg::REQ_DATA) begin
          res_q_next.out_byte = req_q.data_byte;
          stream_offset_next = stream_offset + (ssrm_pkg::OFFSET_W)'(1);
        end else begin
          res_q_next.pad_count = pad[8:0];
          if (end_pos < (ssrm_pkg::OFFSET_W + 1)'(expected_len)) begin
            res_q_next.status = ssrm_pkg::ST_SHORT;
          end
          stream_open_next = 1'b0;
        end
        state_next = ssrm_pkg::S_RESULT;
      end

      ssrm_pkg::S_RESULT: begin
        // Hand over once the result register is free
        if (!res_valid || !res_stall) begin
          res_valid_next = 1'b1;
          state_next = ssrm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ssrm_pkg::S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_offset <= '0;
      error_flag <= 1'b0;
      stream_open <= 1'b0;
      region_total <= '0;
      next_region_offset <= '0;
      cache_valid <= 1'b0;
      res_valid <= 1'b0;
      expected_len <= '0;
    end else begin
      stream_offset <= stream_offset_next;
      error_flag <= error_flag_next;
      stream_open <= stream_open_next;
      region_total <= region_total_next;
      next_region_offset <= next_region_offset_next;
      cache_valid <= cache_valid_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        expected_len <= cfg_data;
      end
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_data;
    end
    if (state == ssrm_pkg::S_RESULT && (!res_valid || !res_stall)) begin
      res_data <= res_q;
    end
    res_q <= res_q_next;
    cache_idx <= cache_idx_next;
    cache_try <= cache_try_next;
    scan_idx <= scan_idx_next;
    diff_q <= diff_q_next;
  end

`ifndef ASSERT_OFF
  // A write is only ever reported with an ok or short-image status
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res_data.write_valid || res_data.status == ssrm_pkg::ST_OK ||
                   res_data.status == ssrm_pkg::ST_SHORT))
    else $error("write reported with an error status");

  // Padding is only reported together with the padding sector
  a_pad_write: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.pad_count != '0) |-> res_data.write_valid)
    else $error("pad count without padding sector");

  // The stream position is frozen while the error holds, until a begin
  a_error_hold: assert property (@(posedge clk) disable iff (rst)
    (error_flag && state != ssrm_pkg::S_EXEC) |=> $stable(stream_offset))
    else $error("stream position moved after no-space error");

  // The scan never reads past the loaded regions
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ssrm_pkg::S_CMP) |-> ((ssrm_pkg::CNT_W)'(scan_idx) < region_total))
    else $error("region scan beyond loaded table");

  // The table never holds more regions than it has room for
  a_total_max: assert property (@(posedge clk) disable iff (rst)
    region_total <= (ssrm_pkg::CNT_W)'(ssrm_pkg::MAX_REGIONS))
    else $error("region count exceeds table size");
`endif

endmodule

// ===== hdl/ssrm_region_map.sv =====
// Region table storage and the shared sector match unit.
// Depends on ssrm_pkg for the entry and match types.
module ssrm_region_map (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ssrm_pkg::IDX_W-1:0]  wr_idx,
  input  ssrm_pkg::region_entry_t     wr_entry,
  input  logic [ssrm_pkg::IDX_W-1:0]  rd_idx,
  input  logic [31:0]                 sector,
  output logic [31:0]                 rd_start,
  output ssrm_pkg::match_t            match
);

  ssrm_pkg::region_entry_t table_mem [ssrm_pkg::MAX_REGIONS];
  ssrm_pkg::region_entry_t rd_q;
  logic [31:0] diff;

  // Write one region per load, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_idx] <= wr_entry;
    end
    rd_q <= table_mem[rd_idx];
  end

  // Test the sector against the entry just read
  always_comb begin
    diff = sector - rd_q.offset_sectors;
    match.diff = diff;
    match.hit = (sector >= rd_q.offset_sectors) && (diff < rd_q.capacity_sectors);
  end

  assign rd_start = rd_q.first_lba;

endmodule

// ===== test/stream_sector_region_mapper_tb.sv =====
// Self-checking testbench for stream_sector_region_mapper: directed and random
// request streams, checked against an in-bench model of the region mapping.
// Depends on ssrm_pkg and the RTL in hdl/.
module stream_sector_region_mapper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1450;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          req_valid;
  logic                          req_stall;
  ssrm_pkg::req_t                req_data;
  logic                          res_valid;
  logic                          res_stall = 1'b0;
  ssrm_pkg::res_t                res_data;
  logic                          cfg_we;
  logic [ssrm_pkg::IMAGE_W-1:0]  cfg_data;

  // Model of the mapper state
  logic [31:0]                   map_lba[ssrm_pkg::MAX_REGIONS];
  logic [31:0]                   map_offset[ssrm_pkg::MAX_REGIONS];
  logic [31:0]                   map_capacity[ssrm_pkg::MAX_REGIONS];
  int unsigned                   regions_held;
  logic [31:0]                   next_offset;
  logic [ssrm_pkg::OFFSET_W-1:0] stream_pos;
  logic                          no_space;
  logic                          stream_open;
  logic [ssrm_pkg::IMAGE_W-1:0]  expected_len;

  ssrm_pkg::res_t                predicted_answers[$];
  int                            sender_idle_pct;
  int                            stall_pct;
  int                            failures;
  int                            items_sent;
  int                            results_checked;
  int                            table_full_seen;
  int                            no_space_seen;
  int                            short_seen;

  stream_sector_region_mapper i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Look up the disk sector for an image sector, first matching region wins
  function automatic logic find_sector(input logic [31:0] sector, output logic [31:0] lba);
    logic found;
    found = 1'b0;
    lba = '0;
    for (int i = 0; i < regions_held; i++) begin
      if (!found && sector >= map_offset[i] && (sector - map_offset[i]) < map_capacity[i]) begin
        found = 1'b1;
        lba = map_lba[i] + (sector - map_offset[i]);
      end
    end
    return found;
  endfunction

  // Work out the answer to one request and advance the model state
  function automatic ssrm_pkg::res_t map_request(input ssrm_pkg::req_t r);
    ssrm_pkg::res_t o;
    logic [31:0]    hdr;
    logic [31:0]    cap;
    logic [31:0]    lba;
    logic [9:0]     pad_left;
    logic [40:0]    padded_end;
    logic           hit;
    o = '0;
    hit = 1'b0;
    lba = '0;
    if (r.req_type == ssrm_pkg::REQ_BEGIN) begin
      regions_held = 0;
      next_offset = '0;
      stream_pos = '0;
      no_space = 1'b0;
      stream_open = 1'b1;
    end else if (!stream_open) begin
      o.status = ssrm_pkg::ST_NOT_OPEN;
    end else if (r.req_type == ssrm_pkg::REQ_LOAD) begin
      if (regions_held >= ssrm_pkg::MAX_REGIONS) begin
        o.status = ssrm_pkg::ST_TABLE_FULL;
      end else begin
        hdr = (regions_held == 0) ? ssrm_pkg::MAIN_HDR_SECTORS : ssrm_pkg::SUB_HDR_SECTORS;
        cap = (r.part_length_sectors > hdr) ? r.part_length_sectors - hdr : '0;
        map_lba[regions_held] = r.part_start_lba + hdr;
        map_offset[regions_held] = next_offset;
        map_capacity[regions_held] = cap;
        // saturate the running offset
        next_offset = (cap > ~next_offset) ? '1 : next_offset + cap;
        regions_held++;
      end
    end else if (r.req_type == ssrm_pkg::REQ_DATA) begin
      if (!no_space && stream_pos != ssrm_pkg::OFFSET_MAX) begin
        hit = find_sector(32'(stream_pos[ssrm_pkg::OFFSET_W-1:9]), lba);
      end
      if (!hit) begin
        no_space = 1'b1;
        o.status = ssrm_pkg::ST_NO_SPACE;
      end else begin
        o.write_valid = 1'b1;
        o.dest_lba = lba;
        o.byte_in_sector = stream_pos[8:0];
        o.out_byte = r.data_byte;
        stream_pos++;
      end
    end else begin
      padded_end = {1'b0, stream_pos};
      if (no_space) begin
        o.status = ssrm_pkg::ST_NO_SPACE;
      end else if (stream_pos[8:0] != '0) begin
        pad_left = ssrm_pkg::SECTOR_BYTES - {1'b0, stream_pos[8:0]};
        hit = find_sector(32'(stream_pos[ssrm_pkg::OFFSET_W-1:9]), lba);
        if (hit) begin
          o.write_valid = 1'b1;
          o.dest_lba = lba;
          o.byte_in_sector = stream_pos[8:0];
          o.pad_count = pad_left[8:0];
          padded_end = {1'b0, stream_pos} + 41'(pad_left);
        end else begin
          o.status = ssrm_pkg::ST_NO_SPACE;
        end
      end
      if (o.status == ssrm_pkg::ST_OK && padded_end < 41'(expected_len)) begin
        o.status = ssrm_pkg::ST_SHORT;
      end
      stream_open = 1'b0;
    end
    return o;
  endfunction

  function automatic ssrm_pkg::req_t make_request(input ssrm_pkg::req_type_t t,
                                                  input logic [31:0] start,
                                                  input logic [31:0] len,
                                                  input logic [7:0] b);
    ssrm_pkg::req_t r;
    r.req_type = t;
    r.part_start_lba = start;
    r.part_length_sectors = len;
    r.data_byte = b;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // Present one request after a random gap, hold it until taken, record the answer
  task automatic send_request(input ssrm_pkg::req_t r);
    int             gap;
    ssrm_pkg::res_t answer;
    gap = 0;
    while (gap < 100 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req_data = r;
    do @(posedge clk); while (req_stall);
    answer = map_request(r);
    predicted_answers.push_back(answer);
    items_sent++;
    if (answer.status == ssrm_pkg::ST_TABLE_FULL) table_full_seen++;
    if (answer.status == ssrm_pkg::ST_NO_SPACE) no_space_seen++;
    if (answer.status == ssrm_pkg::ST_SHORT) short_seen++;
    @(negedge clk);
  endtask

  // Drop valid and let every outstanding answer arrive
  task automatic wait_idle();
    req_valid = 1'b0;
    while (predicted_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_expected_len(input logic [ssrm_pkg::IMAGE_W-1:0] value);
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    expected_len = value;
  endtask

  // Load, data and finish on a stream that was never opened
  task automatic test_closed_stream();
    send_request(make_request(ssrm_pkg::REQ_LOAD, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    send_request(make_request(ssrm_pkg::REQ_FINISH, 32'h0, 32'h0, 8'h00));
    wait_idle();
  endtask

  // Fill the table with huge regions: wrapped start, saturated offset, then refuse one more
  task automatic test_table_full_saturation();
    write_expected_len({ssrm_pkg::IMAGE_W{1'b1}});
    send_request(make_request(ssrm_pkg::REQ_BEGIN, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00));
    for (int i = 1; i < ssrm_pkg::MAX_REGIONS; i++) begin
      send_request(make_request(ssrm_pkg::REQ_LOAD, $urandom, 32'hFFFF_FFFF, 8'h00));
    end
    send_request(make_request(ssrm_pkg::REQ_LOAD, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_DATA, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_DATA, 32'h0, 32'h0, 8'hFF));
    // partial sector with the largest image size: padding and short image
    send_request(make_request(ssrm_pkg::REQ_FINISH, 32'h0, 32'h0, 8'h00));
    wait_idle();
  endtask

  // Restart while open, aligned finish, then a region with no room
  task automatic test_restart_no_space();
    write_expected_len('0);
    send_request(make_request(ssrm_pkg::REQ_BEGIN, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_BEGIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    send_request(make_request(ssrm_pkg::REQ_FINISH, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_BEGIN, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_LOAD, 32'h0, 32'h0, 8'h00));
    send_request(make_request(ssrm_pkg::REQ_DATA, 32'h0, 32'h0, 8'h5A));
    send_request(make_request(ssrm_pkg::REQ_DATA, 32'h0, 32'h0, 8'hA5));
    send_request(make_request(ssrm_pkg::REQ_FINISH, 32'h0, 32'h0, 8'h00));
    wait_idle();
  endtask

  // Whole sessions with random regions and bytes, with some stray requests mixed in
  task automatic test_random_sessions();
    int                           target;
    int                           regions;
    int                           bytes;
    logic [31:0]                  hdr;
    logic [31:0]                  len;
    logic [ssrm_pkg::IMAGE_W-1:0] size;
    ssrm_pkg::req_t               stray;
    target = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 86;
          stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 86;
        end
        default: begin
          sender_idle_pct = 6;
          stall_pct = 6;
        end
      endcase
      target += RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        wait_idle();
        bytes = ($urandom_range(2) == 0) ? $urandom_range(520, 900) : $urandom_range(1, 120);
        case ($urandom_range(3))
          0: size = ssrm_pkg::IMAGE_W'({$urandom, $urandom});
          1: size = '0;
          default: size = ssrm_pkg::IMAGE_W'(bytes) +
                          ssrm_pkg::IMAGE_W'($urandom_range(1023)) -
                          ssrm_pkg::IMAGE_W'(512);
        endcase
        write_expected_len(size);
        send_request(make_request(ssrm_pkg::REQ_BEGIN, $urandom, $urandom, 8'($urandom)));
        regions = $urandom_range(1, 5);
        for (int i = 0; i < regions; i++) begin
          hdr = (i == 0) ? ssrm_pkg::MAIN_HDR_SECTORS : ssrm_pkg::SUB_HDR_SECTORS;
          len = ($urandom_range(3) == 0) ? $urandom : hdr + $urandom_range(2);
          send_request(make_request(ssrm_pkg::REQ_LOAD, $urandom, len, 8'($urandom)));
        end
        // cut the byte run short once the phase has its share of requests
        for (int k = 0; k < bytes && items_sent < target; k++) begin
          if ($urandom_range(99) < 3) begin
            stray = make_request(ssrm_pkg::req_type_t'($urandom_range(3)), $urandom,
                                 $urandom, 8'($urandom));
            send_request(stray);
          end else begin
            send_request(make_request(ssrm_pkg::REQ_DATA, $urandom, $urandom,
                                      8'($urandom)));
          end
        end
        send_request(make_request(ssrm_pkg::REQ_FINISH, $urandom, $urandom, 8'($urandom)));
      end
    end
    sender_idle_pct = 0;
    stall_pct = 0;
    wait_idle();
  endtask

  // Receiver stall
  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each taken answer with the oldest prediction
  always @(posedge clk) begin
    ssrm_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (predicted_answers.size() == 0) begin
        $display("%0t: answer with none pending, expected nothing, actual 0x%0h",
                 $time, res_data);
        failures++;
      end else begin
        want = predicted_answers.pop_front();
        check_field("status", want.status, res_data.status);
        check_field("write_valid", want.write_valid, res_data.write_valid);
        check_field("dest_lba", want.dest_lba, res_data.dest_lba);
        check_field("byte_in_sector", want.byte_in_sector, res_data.byte_in_sector);
        check_field("out_byte", want.out_byte, res_data.out_byte);
        check_field("pad_count", want.pad_count, res_data.pad_count);
        results_checked++;
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("%0t: timeout with %0d answers pending", $time, predicted_answers.size());
    $display("stream_sector_region_mapper_tb failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    regions_held = 0;
    next_offset = '0;
    stream_pos = '0;
    no_space = 1'b0;
    stream_open = 1'b0;
    expected_len = '0;
    sender_idle_pct = 0;
    stall_pct = 0;
    failures = 0;
    items_sent = 0;
    results_checked = 0;
    table_full_seen = 0;
    no_space_seen = 0;
    short_seen = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_closed_stream();
    test_table_full_saturation();
    test_restart_no_space();
    test_random_sessions();

    repeat (50) @(negedge clk);
    if (predicted_answers.size() != 0) begin
      $display("%0t: %0d answers never arrived", $time, predicted_answers.size());
      failures++;
    end
    $display("Sent %0d requests over four idle/stall phases, checked %0d answers",
             items_sent, results_checked);
    $display("Answers seen: %0d table full, %0d no space, %0d short image, %0d mismatches",
             table_full_seen, no_space_seen, short_seen, failures);
    if (failures == 0) begin
      $display("stream_sector_region_mapper_tb passed");
    end else begin
      $display("stream_sector_region_mapper_tb failed");
    end
    $finish;
  end

endmodule
